// ===== src/dsp_pkg.sv =====
package dsp_pkg;

    localparam int NUM_TERMS   = 5;
    localparam int NUM_SPECIES = 4;
    localparam int STORE_DEPTH = 128;
    localparam int KINDS       = 3;
    localparam int OUT_SPECIES = 4;
    localparam int SET_SIZE    = NUM_SPECIES * KINDS * NUM_TERMS;

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int CALC_W = 9;
    localparam int TERM_W = (NUM_TERMS > 1) ? $clog2(NUM_TERMS) : 1;
    localparam int SP_W   = (NUM_SPECIES > 1) ? $clog2(NUM_SPECIES) : 1;
    localparam int OUT_W  = (SP_W > 2) ? SP_W : 2;

    localparam int WGT_W = 33;
    localparam int SUM_W = 36;
    localparam int DIV_RW = 36;
    localparam int DIV_LW = 19;
    localparam int DIV_CW = 5;

    localparam int GAUSS_BITS = 19;
    localparam int PROB_BITS  = 16;
    localparam int EXP_TERMS  = 12;

    localparam logic [0:0] OP_LOAD     = 1'b0;
    localparam logic [0:0] OP_CLASSIFY = 1'b1;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    typedef struct packed {
        logic              start;
        logic [DIV_RW-1:0] rem0;
        logic [DIV_LW-1:0] low;
        logic [DIV_CW-1:0] nbits;
        logic [DIV_RW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_LW-1:0] quo;
    } div_rsp_t;

    // exp(-2^k) in q0.30, k = -8 .. 3
    function automatic logic [29:0] exp_tab(input logic [3:0] b);
        logic [29:0] v;
        unique case (b)
            4'd0:    v = 30'd1069555701;
            4'd1:    v = 30'd1065385899;
            4'd2:    v = 30'd1057095000;
            4'd3:    v = 30'd1040706261;
            4'd4:    v = 30'd1008687096;
            4'd5:    v = 30'd947573834;
            4'd6:    v = 30'd836230973;
            4'd7:    v = 30'd651257337;
            4'd8:    v = 30'd395007542;
            4'd9:    v = 30'd145315154;
            4'd10:   v = 30'd19666267;
            4'd11:   v = 30'd360200;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
        logic signed [31:0] r;
        if (x > 48'sh0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (x < -48'sh0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

// ===== src/dsp_if.sv =====
interface dsp_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic [6:0]         coeff_index;
    logic signed [31:0] coeff_value;
    logic               negative_charge;
    logic [23:0]        momentum;
    logic [15:0]        energy_loss;

    modport source (output valid, op, coeff_index, coeff_value, negative_charge,
                    momentum, energy_loss, input ready);
    modport sink (input valid, op, coeff_index, coeff_value, negative_charge,
                  momentum, energy_loss, output ready);
endinterface

interface dsp_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        prob_pion;
    logic [15:0]        prob_kaon;
    logic [15:0]        prob_proton;
    logic [15:0]        prob_electron;
    logic signed [31:0] amplitude_sum;
    logic               invalid;

    modport source (output valid, prob_pion, prob_kaon, prob_proton, prob_electron,
                    amplitude_sum, invalid, input ready);
    modport sink (input valid, prob_pion, prob_kaon, prob_proton, prob_electron,
                  amplitude_sum, invalid, output ready);
endinterface

// ===== src/dsp_ram.sv =====
module dsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== src/dsp_div.sv =====
module dsp_div
    import dsp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [DIV_RW-1:0] rem_reg;
    logic [DIV_RW-1:0] div_reg;
    logic [DIV_LW-1:0] low_reg;
    logic [DIV_LW-1:0] quo_reg;
    logic [DIV_RW:0]   trial;
    logic              ge;

    // restoring division, one quotient bit a cycle
    assign trial = {rem_reg, low_reg[DIV_LW-1]};
    assign ge    = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.nbits;
                rem_reg  <= req.rem0;
                div_reg  <= req.divisor;
                low_reg  <= req.low;
                quo_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? DIV_RW'(trial - {1'b0, div_reg}) : trial[DIV_RW-1:0];
                quo_reg <= {quo_reg[DIV_LW-2:0], ge};
                low_reg <= {low_reg[DIV_LW-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg)
        else $error("divider done while busy");
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> !done_reg)
        else $error("divider done overlaps run");
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !req.start) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("divider count skipped");
endmodule

// ===== src/dedx_species_probability.sv =====
// classify: the result is registered in S_DONE, and the next request can be accepted in the
// cycle after; per species 15 coefficient reads with Horner multiply-adds, the ratio
// division if not far, up to 12 exp steps and S_GS, S_SQ, S_W, S_WACC; then the probability divisions
// load: one coefficient write per cycle while idle, one request accepted at a time
// a stalled result holds the following track in its final state
// reset clears the control state only; the coefficient store is undefined until written
module dedx_species_probability
    import dsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    dsp_in_if.sink    in_ch,
    dsp_out_if.source out_ch
);
    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_DAT, S_MUL, S_GS, S_GDIV, S_SQ, S_EXP,
        S_W, S_WACC, S_PROB, S_PDIV, S_DONE
    } state_t;

    state_t state_reg;

    logic [CALC_W-1:0]  poly_base_reg;
    logic [TERM_W-1:0]  k_reg;
    logic [1:0]         kind_reg;
    logic [SP_W-1:0]    sp_reg;
    logic [OUT_W-1:0]   j_reg;
    logic [3:0]         b_reg;
    logic [23:0]        p_reg;
    logic [15:0]        dedx_reg;
    logic signed [31:0] acc_reg;
    logic signed [56:0] prod_reg;
    logic signed [31:0] amp_reg;
    logic signed [31:0] mean_reg;
    logic signed [31:0] sig_reg;
    logic [GAUSS_BITS-1:0] q_reg;
    logic [20:0]        e_reg;
    logic [30:0]        g_reg;
    logic signed [63:0] wprod_reg;
    logic signed [WGT_W-1:0] w_reg [NUM_SPECIES];
    logic signed [SUM_W-1:0] sum_reg;
    logic               bad_reg;
    logic               oob_reg;
    logic [15:0]        prob_reg [OUT_SPECIES];

    logic               out_valid_reg;
    logic [15:0]        out_prob_reg [OUT_SPECIES];
    logic signed [31:0] out_sum_reg;
    logic               out_invalid_reg;

    // coefficient store access
    logic [CALC_W-1:0]  rd_calc;
    logic               rd_oob;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [31:0]        ram_rdata;
    logic               in_acc;

    assign in_acc   = in_ch.valid && in_ch.ready;
    assign rd_calc  = poly_base_reg + CALC_W'(k_reg);
    assign rd_oob   = rd_calc >= CALC_W'(STORE_DEPTH);
    assign ram_we   = (state_reg == S_IDLE) && in_acc && (in_ch.op == OP_LOAD)
                      && ({2'b00, in_ch.coeff_index} < CALC_W'(STORE_DEPTH));
    assign ram_addr = (state_reg == S_IDLE) ? ADDR_W'(in_ch.coeff_index)
                                            : rd_calc[ADDR_W-1:0];

    dsp_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (in_ch.coeff_value),
        .rdata (ram_rdata)
    );

    // horner step
    logic signed [31:0] coeff;
    logic signed [41:0] horner_sum;
    logic signed [31:0] poly_val;

    assign coeff      = oob_reg ? 32'sd0 : $signed(ram_rdata);
    assign horner_sum = 42'(prod_reg >>> 16) + 42'(coeff);
    assign poly_val   = (k_reg == TERM_W'(NUM_TERMS - 1)) ? coeff
                                                          : sat32(48'(horner_sum));

    // gaussian distance
    logic signed [32:0] dist_s;
    logic [31:0]        dist_mag;
    logic [31:0]        sig_mag;
    logic               far;

    assign dist_s   = $signed({13'd0, dedx_reg, 4'd0}) - 33'(mean_reg);
    assign dist_mag = dist_s[32] ? 32'(-dist_s) : dist_s[31:0];
    assign sig_mag  = sig_reg[31] ? 32'(-sig_reg) : sig_reg;
    assign far      = {3'b000, dist_mag} >= {sig_mag, 3'b000};

    logic [37:0] q_sq;
    logic [60:0] g_prod;
    assign q_sq   = 38'(q_reg) * 38'(q_reg);
    assign g_prod = 61'(g_reg) * 61'(exp_tab(b_reg));

    // probability selection
    logic signed [WGT_W-1:0] sel_w;
    logic                    bad_all;
    logic                    j_live;

    assign j_live  = 32'(j_reg) < NUM_SPECIES;
    assign sel_w   = j_live ? w_reg[j_reg[SP_W-1:0]] : '0;
    assign bad_all = bad_reg || (sum_reg <= 0);

    div_req_t div_req;
    div_rsp_t div_rsp;

    always_comb
    begin
        div_req = '0;
        if (state_reg == S_GS && sig_reg != 0 && !far)
        begin
            div_req.start   = 1'b1;
            div_req.rem0    = DIV_RW'(dist_mag[31:3]);
            div_req.low     = {dist_mag[2:0], 16'd0};
            div_req.nbits   = DIV_CW'(GAUSS_BITS);
            div_req.divisor = DIV_RW'(sig_mag);
        end
        else if (state_reg == S_PROB && !bad_all && sel_w > 0
                 && 36'(sel_w) < sum_reg)
        begin
            div_req.start   = 1'b1;
            div_req.rem0    = DIV_RW'(sel_w);
            div_req.low     = '0;
            div_req.nbits   = DIV_CW'(PROB_BITS);
            div_req.divisor = DIV_RW'(sum_reg);
        end
    end

    dsp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_ch.ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            bad_reg       <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && in_ch.op == OP_CLASSIFY)
                    begin
                        poly_base_reg <= in_ch.negative_charge ? CALC_W'(SET_SIZE) : '0;
                        k_reg         <= TERM_W'(NUM_TERMS - 1);
                        kind_reg      <= 2'd0;
                        sp_reg        <= '0;
                        sum_reg       <= '0;
                        bad_reg       <= 1'b0;
                        p_reg         <= in_ch.momentum;
                        dedx_reg      <= in_ch.energy_loss;
                        state_reg     <= S_RD;
                    end
                end
                S_RD:
                begin
                    oob_reg   <= rd_oob;
                    state_reg <= S_DAT;
                end
                S_MUL:
                begin
                    prod_reg  <= acc_reg * $signed({1'b0, p_reg});
                    oob_reg   <= rd_oob;
                    state_reg <= S_DAT;
                end
                S_DAT:
                begin
                    if (k_reg != '0)
                    begin
                        acc_reg   <= poly_val;
                        k_reg     <= k_reg - 1'b1;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        unique case (kind_reg)
                            2'd0:    amp_reg  <= poly_val;
                            2'd1:    mean_reg <= poly_val;
                            default: sig_reg  <= poly_val;
                        endcase
                        poly_base_reg <= poly_base_reg + CALC_W'(NUM_TERMS);
                        k_reg         <= TERM_W'(NUM_TERMS - 1);
                        if (kind_reg == 2'd2)
                        begin
                            kind_reg  <= 2'd0;
                            state_reg <= S_GS;
                        end
                        else
                        begin
                            kind_reg  <= kind_reg + 1'b1;
                            state_reg <= S_RD;
                        end
                    end
                end
                S_GS:
                begin
                    if (sig_reg == 0)
                    begin
                        bad_reg   <= 1'b1;
                        g_reg     <= '0;
                        state_reg <= S_W;
                    end
                    else if (far)
                    begin
                        g_reg     <= '0;
                        state_reg <= S_W;
                    end
                    else
                    begin
                        state_reg <= S_GDIV;
                    end
                end
                S_GDIV:
                begin
                    if (div_rsp.done)
                    begin
                        q_reg     <= div_rsp.quo;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    e_reg     <= q_sq[37:17];
                    b_reg     <= 4'd0;
                    g_reg     <= ONE_Q30;
                    state_reg <= S_EXP;
                end
                S_EXP:
                begin
                    if (e_reg[20])
                    begin
                        g_reg     <= '0;
                        state_reg <= S_W;
                    end
                    else
                    begin
                        if (e_reg[5'(b_reg) + 5'd8])
                        begin
                            g_reg <= g_prod[60:30];
                        end
                        b_reg <= b_reg + 1'b1;
                        if (b_reg == 4'(EXP_TERMS - 1))
                        begin
                            state_reg <= S_W;
                        end
                    end
                end
                S_W:
                begin
                    wprod_reg <= 64'(amp_reg) * 64'($signed({1'b0, g_reg}));
                    state_reg <= S_WACC;
                end
                S_WACC:
                begin
                    w_reg[sp_reg] <= wprod_reg[62:30];
                    sum_reg       <= sum_reg + SUM_W'($signed(wprod_reg[62:30]));
                    if (sp_reg == SP_W'(NUM_SPECIES - 1))
                    begin
                        j_reg     <= '0;
                        state_reg <= S_PROB;
                    end
                    else
                    begin
                        sp_reg    <= sp_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_PROB:
                begin
                    if (div_req.start)
                    begin
                        state_reg <= S_PDIV;
                    end
                    else
                    begin
                        prob_reg[j_reg[1:0]] <= (!bad_all && sel_w > 0) ? 16'hFFFF : 16'd0;
                        if (j_reg == OUT_W'(OUT_SPECIES - 1))
                            state_reg <= S_DONE;
                        else
                            j_reg <= j_reg + 1'b1;
                    end
                end
                S_PDIV:
                begin
                    if (div_rsp.done)
                    begin
                        prob_reg[j_reg[1:0]] <= div_rsp.quo[15:0];
                        if (j_reg == OUT_W'(OUT_SPECIES - 1))
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_PROB;
                        end
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_prob_reg    <= prob_reg;
                        out_sum_reg     <= sat32(48'(sum_reg));
                        out_invalid_reg <= bad_all;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.prob_pion     = out_prob_reg[0];
    assign out_ch.prob_kaon     = out_prob_reg[1];
    assign out_ch.prob_proton   = out_prob_reg[2];
    assign out_ch.prob_electron = out_prob_reg[3];
    assign out_ch.amplitude_sum = out_sum_reg;
    assign out_ch.invalid       = out_invalid_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.busy |-> (state_reg == S_GDIV || state_reg == S_PDIV))
        else $error("divider running outside a division wait");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.invalid) |->
        (out_ch.prob_pion == 16'd0 && out_ch.prob_kaon == 16'd0 &&
         out_ch.prob_proton == 16'd0 && out_ch.prob_electron == 16'd0))
        else $error("probabilities reported on an invalid track");
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_IDLE && in_ch.op == OP_LOAD))
        else $error("store written outside a load request");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !out_ch.ready) |=> state_reg == S_DONE)
        else $error("result dropped while output stalled");
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb
    import dsp_pkg::*;
;

    typedef struct {
        logic        op;
        logic [6:0]  coeff_index;
        logic [31:0] coeff_value;
        logic        negative_charge;
        logic [23:0] momentum;
        logic [15:0] energy_loss;
    } track_req_t;

    typedef struct {
        logic [15:0] prob [OUT_SPECIES];
        logic [31:0] amplitude_sum;
        logic        invalid;
    } pid_result_t;

    logic clk;
    logic rst_n;

    dsp_in_if  in_ch ();
    dsp_out_if out_ch ();

    dedx_species_probability i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    track_req_t  pending_reqs [$];
    pid_result_t expected_pid [$];
    logic [31:0] fit_table [STORE_DEPTH];
    int          error_count;
    bit          quiet_phase;
    bit          hold_send;
    bit          in_taken;
    int          send_gap;
    int          recv_gap;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic signed [63:0] floor_sh(input logic signed [63:0] x, input int s);
        return x >>> s;
    endfunction

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic logic signed [63:0] fit_word(input int idx);
        if (idx >= STORE_DEPTH)
            return 0;
        return {{32{fit_table[idx][31]}}, fit_table[idx]};
    endfunction

    function automatic logic signed [63:0] eval_poly(input int base, input logic signed [63:0] p);
        logic signed [63:0] acc;
        acc = fit_word(base + NUM_TERMS - 1);
        for (int k = NUM_TERMS - 2; k >= 0; k--)
            acc = clamp32(floor_sh(acc * p, 16) + fit_word(base + k));
        return acc;
    endfunction

    function automatic logic [63:0] gauss_weight(input logic [63:0] d_mag, input logic [63:0] sig);
        logic [63:0] q;
        logic [63:0] e;
        logic [63:0] g;
        logic [63:0] tab [12];
        tab = '{64'd1069555701, 64'd1065385899, 64'd1057095000, 64'd1040706261,
                64'd1008687096, 64'd947573834, 64'd836230973, 64'd651257337,
                64'd395007542, 64'd145315154, 64'd19666267, 64'd360200};
        q = (d_mag << 16) / sig;
        if (q >= (64'd8 << 16))
            return 0;
        e = (q * q) >> 17;
        if (e >= (64'd16 << 16))
            return 0;
        g = 64'd1073741824;
        for (int b = 0; b < 12; b++)
            if (e[b + 8])
                g = (g * tab[b]) >> 30;
        return g;
    endfunction

    function automatic pid_result_t classify_track(input track_req_t r);
        pid_result_t res;
        logic signed [63:0] w [NUM_SPECIES];
        logic signed [63:0] sum;
        logic signed [63:0] p;
        logic signed [63:0] dedx;
        logic signed [63:0] amp;
        logic signed [63:0] mean;
        logic signed [63:0] sig;
        logic signed [63:0] d;
        logic signed [63:0] s;
        logic [63:0] g;
        logic [63:0] pr;
        int base;
        int row;
        bit bad;
        sum = 0;
        bad = 0;
        base = r.negative_charge ? SET_SIZE : 0;
        p = {40'd0, r.momentum};
        dedx = {44'd0, r.energy_loss, 4'd0};
        for (int sp = 0; sp < NUM_SPECIES; sp++)
        begin
            row = base + sp * KINDS * NUM_TERMS;
            amp = eval_poly(row, p);
            mean = eval_poly(row + NUM_TERMS, p);
            sig = eval_poly(row + 2 * NUM_TERMS, p);
            d = dedx - mean;
            w[sp] = 0;
            if (sig == 0)
            begin
                bad = 1;
                continue;
            end
            g = gauss_weight(d < 0 ? -d : d, sig < 0 ? -sig : sig);
            w[sp] = floor_sh(amp * $signed(g), 30);
            sum += w[sp];
        end
        if (sum <= 0)
            bad = 1;
        for (int j = 0; j < OUT_SPECIES; j++)
        begin
            pr = 0;
            if (!bad && j < NUM_SPECIES && w[j] > 0)
            begin
                pr = (64'(w[j]) << 16) / 64'(sum);
                if (pr > 65535)
                    pr = 65535;
            end
            res.prob[j] = pr[15:0];
        end
        s = clamp32(sum);
        res.amplitude_sum = s[31:0];
        res.invalid = bad;
        return res;
    endfunction

    // predict at acceptance, in request order
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            track_req_t r;
            r.op = in_ch.op;
            r.coeff_index = in_ch.coeff_index;
            r.coeff_value = in_ch.coeff_value;
            r.negative_charge = in_ch.negative_charge;
            r.momentum = in_ch.momentum;
            r.energy_loss = in_ch.energy_loss;
            if (r.op == OP_LOAD)
            begin
                if (r.coeff_index < STORE_DEPTH)
                    fit_table[r.coeff_index] = r.coeff_value;
            end
            else
                expected_pid.push_back(classify_track(r));
            in_taken = 1'b1;
        end
    end

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (!in_ch.valid || in_taken)
        begin
            in_taken = 1'b0;
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_ch.valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0 && !hold_send)
            begin
                track_req_t r;
                r = pending_reqs.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.op <= r.op;
                in_ch.coeff_index <= r.coeff_index;
                in_ch.coeff_value <= r.coeff_value;
                in_ch.negative_charge <= r.negative_charge;
                in_ch.momentum <= r.momentum;
                in_ch.energy_loss <= r.energy_loss;
                if (!quiet_phase && $urandom_range(0, 9) == 0)
                    send_gap <= $urandom_range(1, 15);
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            out_ch.ready <= 1'b0;
        end
        else if (!quiet_phase && $urandom_range(0, 7) == 0)
        begin
            recv_gap <= $urandom_range(0, 14);
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            logic [15:0] got [OUT_SPECIES];
            pid_result_t exp_r;
            got[0] = out_ch.prob_pion;
            got[1] = out_ch.prob_kaon;
            got[2] = out_ch.prob_proton;
            got[3] = out_ch.prob_electron;
            if (expected_pid.size() == 0)
            begin
                $display("%t: unexpected result, expected none, actual sum %h", $realtime,
                         out_ch.amplitude_sum);
                error_count++;
            end
            else
            begin
                exp_r = expected_pid.pop_front();
                for (int j = 0; j < OUT_SPECIES; j++)
                    if (got[j] !== exp_r.prob[j])
                    begin
                        $display("%t: prob[%0d] expected %h actual %h", $realtime, j,
                                 exp_r.prob[j], got[j]);
                        error_count++;
                    end
                if (out_ch.amplitude_sum !== exp_r.amplitude_sum)
                begin
                    $display("%t: amplitude_sum expected %h actual %h", $realtime,
                             exp_r.amplitude_sum, out_ch.amplitude_sum);
                    error_count++;
                end
                if (out_ch.invalid !== exp_r.invalid)
                begin
                    $display("%t: invalid expected %b actual %b", $realtime,
                             exp_r.invalid, out_ch.invalid);
                    error_count++;
                end
            end
        end
    end

    task automatic add_load(input int idx, input logic [31:0] v);
        track_req_t r;
        r = '{default: '0};
        r.op = OP_LOAD;
        r.coeff_index = 7'(idx);
        r.coeff_value = v;
        r.negative_charge = 1'($urandom_range(0, 1));
        r.momentum = 24'($urandom);
        r.energy_loss = 16'($urandom);
        pending_reqs.push_back(r);
    endtask

    task automatic add_track(input logic neg, input logic [23:0] p, input logic [15:0] e);
        track_req_t r;
        r.op = OP_CLASSIFY;
        r.coeff_index = 7'($urandom);
        r.coeff_value = $urandom;
        r.negative_charge = neg;
        r.momentum = p;
        r.energy_loss = e;
        pending_reqs.push_back(r);
    endtask

    // fit set: in styles 0 and 2 constant terms dominate with small higher powers, style 2 negating
    task automatic load_fit_set(input int charge, input int style);
        int idx;
        logic [31:0] v;
        for (int sp = 0; sp < NUM_SPECIES; sp++)
            for (int kind = 0; kind < KINDS; kind++)
                for (int pw = 0; pw < NUM_TERMS; pw++)
                begin
                    idx = charge * SET_SIZE + (sp * KINDS + kind) * NUM_TERMS + pw;
                    if (style == 1)
                        v = $urandom;
                    else if (pw == 0)
                    begin
                        case (kind)
                            0: v = $urandom_range(0, 32'h0004_0000);
                            1: v = $urandom_range(32'h0000_4000, 32'h0008_0000);
                            default: v = $urandom_range(32'h0000_0800, 32'h0002_0000);
                        endcase
                        if (style == 2 && $urandom_range(0, 3) == 0)
                            v = -v;
                    end
                    else
                        v = $signed($urandom_range(0, 32'h0000_0400)) - 32'sh200;
                    add_load(idx, v);
                end
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || in_ch.valid || expected_pid.size() > 0)
            @(posedge clk);
    endtask

    task automatic random_tracks(input int n, input int charge_mask);
        for (int i = 0; i < n; i++)
            add_track(1'(charge_mask == 2 ? $urandom_range(0, 1) : charge_mask),
                      24'($urandom_range(0, 3) == 0 ? $urandom
                                                    : $urandom_range(0, 24'h04_0000)),
                      16'($urandom_range(0, 4) == 0 ? $urandom
                                                    : $urandom_range(0, 16'h9000)));
    endtask

    initial
    begin
        int idx;
        rst_n = 1'b0;
        error_count = 0;
        quiet_phase = 0;
        hold_send = 0;
        in_taken = 0;
        send_gap = 0;
        recv_gap = 0;
        in_ch.valid = 1'b0;
        in_ch.op = OP_LOAD;
        in_ch.coeff_index = '0;
        in_ch.coeff_value = '0;
        in_ch.negative_charge = 1'b0;
        in_ch.momentum = '0;
        in_ch.energy_loss = '0;
        out_ch.ready = 1'b0;
        for (int i = 0; i < STORE_DEPTH; i++)
            fit_table[i] = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: both sets written in full, then extremes
        load_fit_set(0, 0);
        load_fit_set(1, 0);
        add_track(0, 24'h000000, 16'h0000);
        add_track(1, 24'hFFFFFF, 16'hFFFF);
        add_track(0, 24'h010000, 16'h4000);
        add_track(1, 24'h000100, 16'h1000);
        // spare entries above both sets
        add_load(7'd127, 32'h7FFF_FFFF);
        add_load(7'd120, 32'h8000_0000);
        // zero sigma on pion of the positive set
        add_load(2 * NUM_TERMS + 0, 32'h0);
        add_load(2 * NUM_TERMS + 1, 32'h0);
        add_load(2 * NUM_TERMS + 2, 32'h0);
        add_load(2 * NUM_TERMS + 3, 32'h0);
        add_load(2 * NUM_TERMS + 4, 32'h0);
        add_track(0, 24'h020000, 16'h2000);
        // negative sigma and a negative amplitude on the pion
        add_load(2 * NUM_TERMS, 32'hFFFF_0000);
        add_load(0, 32'hFFFE_0000);
        add_track(0, 24'h000000, 16'h1000);
        add_track(0, 24'h800000, 16'h0001);
        wait_idle();

        // random tracks between fit set reloads; after phase 2, a pause until every result is back
        random_tracks(250, 2);
        for (int phase = 0; phase < 6; phase++)
        begin
            load_fit_set($urandom_range(0, 1), phase % 3);
            for (int k = 0; k < 10; k++)
            begin
                idx = $urandom_range(0, 127);
                add_load(idx, $urandom_range(0, 1) ? $urandom : 32'h0);
            end
            if (phase == 5)
                quiet_phase = 1;
            random_tracks(150, 2);
            if (phase == 2)
            begin
                hold_send = 1;
                while (in_ch.valid || expected_pid.size() > 0)
                    @(posedge clk);
                hold_send = 0;
            end
        end
        // extreme coefficients
        for (int k = 0; k < 40; k++)
            add_load($urandom_range(0, 127), $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
        random_tracks(80, 2);

        wait_idle();
        repeat (300) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
src/dsp_pkg.sv
src/dsp_if.sv
src/dsp_ram.sv
src/dsp_div.sv
src/dedx_species_probability.sv
bench/tb.sv
